@@ rtl/clnb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_pkg
// Shared types, codes and defaults for the cell-list neighbor binning engine.
// ----------------------------------------------------------------------------
package clnb_pkg;

  localparam int GRID_DIM_DEF      = 16;
  localparam int CELL_CAP_DEF      = 8;
  localparam int MAX_PARTICLES_DEF = 1024;

  localparam int MAX_OUT = 64;
  localparam int OUT_CW  = $clog2(MAX_OUT + 1);

  localparam int POS_W  = 24;
  localparam int ID_W   = 10;
  localparam int CFG_W  = 24;
  localparam int CELL_W = 16;

  localparam logic [22:0] HALF_BOX_RST  = 23'd3276800;
  localparam logic [23:0] INV_CELL_RST  = 24'd10486;
  localparam logic [4:0]  CELLS_AX_RST  = 5'd16;

  localparam logic [1:0] REG_HALF_BOX = 2'd0;
  localparam logic [1:0] REG_INV_CELL = 2'd1;
  localparam logic [1:0] REG_CELLS_AX = 2'd2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [ID_W-1:0]        particle_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] neighbor_id;
    logic            found;
    logic            last;
    logic [1:0]      status;
  } out_t;

endpackage

@@ rtl/clnb_bin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnb_bin
// Two-stage binning: offset add, then scale by the inverse cell size and
// range check, for all three axes in parallel.
// ----------------------------------------------------------------------------
module clnb_bin #(
  parameter int GRID_DIM = clnb_pkg::GRID_DIM_DEF
) (
  input  logic                                  clk_i,
  input  logic signed [clnb_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [clnb_pkg::POS_W-1:0]     pos_y_i,
  input  logic signed [clnb_pkg::POS_W-1:0]     pos_z_i,
  input  logic [22:0]                           half_box_i,
  input  logic [23:0]                           inv_cell_i,
  input  logic [clnb_pkg::CELL_W-1:0]           eff_dim_i,
  output logic                                  outside_o,
  output logic [$clog2(GRID_DIM)-1:0]           cx_o,
  output logic [$clog2(GRID_DIM)-1:0]           cy_o,
  output logic [$clog2(GRID_DIM)-1:0]           cz_o
);
  import clnb_pkg::*;

  localparam int CW = $clog2(GRID_DIM);

  logic signed [POS_W-1:0] pos [3];
  logic signed [POS_W:0]   sum_d [3];
  logic signed [POS_W:0]   sum_q [3];
  logic [47:0]             prod [3];
  logic [CELL_W-1:0]       bin_idx [3];
  logic [2:0]              out_d, out_q;
  logic [CW-1:0]           cell_q [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign sum_d[i]   = {pos[i][POS_W-1], pos[i]} + $signed({2'b00, half_box_i});
    assign prod[i]    = 48'(sum_q[i][POS_W-1:0]) * 48'(inv_cell_i);
    assign bin_idx[i] = prod[i][47:32];
    assign out_d[i]   = sum_q[i][POS_W] || (bin_idx[i] >= eff_dim_i);

    always_ff @(posedge clk_i) begin
      sum_q[i]  <= sum_d[i];
      out_q[i]  <= out_d[i];
      cell_q[i] <= bin_idx[i][CW-1:0];
    end
  end

  assign outside_o = |out_q;
  assign cx_o      = cell_q[0];
  assign cy_o      = cell_q[1];
  assign cz_o      = cell_q[2];

endmodule

@@ rtl/cell_list_neighbor_binning.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_list_neighbor_binning
// Cell-list binning engine: clear, entry, nop and 3x3x3 neighbor query over
// a cell count memory and a cell member memory.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid_i / in_ready_o / in_data_i   | item in
//  out     | out_valid_o / out_ready_i / out_data_o| results out
//  cfg     | cfg_we_i / cfg_idx_i / cfg_wdata_i    | register write
//
//  One item at a time. Entry: bin, evaluate, read count, write if room, respond.
//  Outside or boundary: bin, evaluate, respond. Nop: respond. Query: read the
//  27 neighbor counts to size the result, then each cell's count and members.
//  Clear and reset: sweep over all GRID_DIM^3 count memory cells, no item
//  accepted meanwhile. Output stalls hold the sequencer in place.
// ----------------------------------------------------------------------------
module cell_list_neighbor_binning #(
  parameter int GRID_DIM      = clnb_pkg::GRID_DIM_DEF,
  parameter int CELL_CAP      = clnb_pkg::CELL_CAP_DEF,
  parameter int MAX_PARTICLES = clnb_pkg::MAX_PARTICLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  clnb_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output clnb_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [clnb_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import clnb_pkg::*;

  localparam int CW    = $clog2(GRID_DIM);
  localparam int NCELL = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(NCELL);
  localparam int NMEM  = NCELL * CELL_CAP;
  localparam int MW    = $clog2(NMEM);
  localparam int CNTW  = $clog2(CELL_CAP + 1);
  localparam int TW    = $clog2(27 * CELL_CAP + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_BIN  = 4'd2;
  localparam logic [3:0] S_EVAL = 4'd3;
  localparam logic [3:0] S_EWR  = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SACC = 4'd6;
  localparam logic [3:0] S_CRD  = 4'd7;
  localparam logic [3:0] S_CGET = 4'd8;
  localparam logic [3:0] S_MRD  = 4'd9;
  localparam logic [3:0] S_MOUT = 4'd10;
  localparam logic [3:0] S_RESP = 4'd11;

  // configuration
  logic [22:0] half_box_q;
  logic [23:0] inv_cell_q;
  logic [4:0]  cells_ax_q;
  logic [CELL_W-1:0] eff_dim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_box_q <= HALF_BOX_RST;
      inv_cell_q <= INV_CELL_RST;
      cells_ax_q <= CELLS_AX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_BOX: half_box_q <= cfg_wdata_i[22:0];
        REG_INV_CELL: inv_cell_q <= cfg_wdata_i[23:0];
        REG_CELLS_AX: cells_ax_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign eff_dim = (CELL_W'(cells_ax_q) < CELL_W'(GRID_DIM)) ? CELL_W'(cells_ax_q)
                                                             : CELL_W'(GRID_DIM);

  // control and item registers
  logic [3:0]      state_q, state_d;
  in_t             item_q;
  logic            bin_cnt_q, bin_cnt_d;
  logic            clr_resp_q, clr_resp_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic [1:0]      resp_st_q, resp_st_d;
  logic [AW-1:0]   cell_q, cell_d;
  logic [CW-1:0]   bx_q, by_q, bz_q;
  logic [1:0]      dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic [TW-1:0]   total_q, total_d;
  logic [OUT_CW-1:0] lim_q, lim_d, k_q, k_d;
  logic            trunc_q, trunc_d;
  logic [CNTW-1:0] m_q, m_d, cur_q, cur_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  // binning
  logic          outside;
  logic [CW-1:0] cx, cy, cz;

  clnb_bin #(.GRID_DIM(GRID_DIM)) u_bin (
    .clk_i      (clk_i),
    .pos_x_i    (item_q.pos_x),
    .pos_y_i    (item_q.pos_y),
    .pos_z_i    (item_q.pos_z),
    .half_box_i (half_box_q),
    .inv_cell_i (inv_cell_q),
    .eff_dim_i  (eff_dim),
    .outside_o  (outside),
    .cx_o       (cx),
    .cy_o       (cy),
    .cz_o       (cz)
  );

  function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic [CW-1:0] z);
    return AW'(x) * AW'(GRID_DIM * GRID_DIM) + AW'(y) * AW'(GRID_DIM) + AW'(z);
  endfunction

  // memories
  logic [CNTW-1:0] cnt_mem [NCELL];
  logic [ID_W-1:0] mem_mem [NMEM];
  logic            cnt_re, cnt_we, mem_re, mem_we;
  logic [AW-1:0]   cnt_raddr, cnt_waddr;
  logic [CNTW-1:0] cnt_wdata, cnt_rdata_q;
  logic [MW-1:0]   mem_raddr, mem_waddr;
  logic [ID_W-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_mem[mem_waddr] <= item_q.particle_id;
    if (mem_re) mem_rdata_q <= mem_mem[mem_raddr];
  end

  // neighbor walk
  logic [CW-1:0] nx, ny, nz;
  logic [AW-1:0] nb_addr;
  logic          nb_last;
  logic [TW-1:0] total_nx;
  logic          out_free;
  logic          boundary;
  logic [CELL_W-1:0] dim_m1;

  assign nx       = bx_q + CW'(dx_q);
  assign ny       = by_q + CW'(dy_q);
  assign nz       = bz_q + CW'(dz_q);
  assign nb_addr  = cell_addr(nx, ny, nz);
  assign nb_last  = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);
  assign total_nx = total_q + TW'(cnt_rdata_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign dim_m1   = eff_dim - CELL_W'(1);
  assign boundary = (cx == '0) || (cy == '0) || (cz == '0) ||
                    (CELL_W'(cx) == dim_m1) || (CELL_W'(cy) == dim_m1) ||
                    (CELL_W'(cz) == dim_m1);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    bin_cnt_d   = bin_cnt_q;
    clr_resp_d  = clr_resp_q;
    clr_addr_d  = clr_addr_q;
    resp_st_d   = resp_st_q;
    cell_d      = cell_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    dz_d        = dz_q;
    total_d     = total_q;
    lim_d       = lim_q;
    k_d         = k_q;
    trunc_d     = trunc_q;
    m_d         = m_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cnt_re      = 1'b0;
    cnt_we      = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    cnt_raddr   = nb_addr;
    cnt_waddr   = cell_q;
    cnt_wdata   = cnt_rdata_q + CNTW'(1);
    mem_raddr   = MW'(cell_q) * MW'(CELL_CAP) + MW'(m_q);
    mem_waddr   = MW'(cell_q) * MW'(CELL_CAP) + MW'(cnt_rdata_q);

    unique case (state_q)
      S_CLR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = clr_addr_q;
        cnt_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(NCELL - 1)) begin
          resp_st_d = ST_OK;
          state_d   = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.op)
            OP_CLEAR: begin
              clr_addr_d = '0;
              clr_resp_d = 1'b1;
              state_d    = S_CLR;
            end
            OP_ENTRY, OP_QUERY: begin
              bin_cnt_d = 1'b0;
              state_d   = S_BIN;
            end
            default: begin
              resp_st_d = ST_OK;
              state_d   = S_RESP;
            end
          endcase
        end
      end
      S_BIN: begin
        bin_cnt_d = 1'b1;
        if (bin_cnt_q) state_d = S_EVAL;
      end
      S_EVAL: begin
        cell_d = cell_addr(cx, cy, cz);
        if (outside) begin
          resp_st_d = ST_OUTSIDE;
          state_d   = S_RESP;
        end else if (item_q.op == OP_ENTRY) begin
          if (32'(item_q.particle_id) >= 32'(MAX_PARTICLES)) begin
            resp_st_d = ST_OUTSIDE;
            state_d   = S_RESP;
          end else begin
            cnt_re    = 1'b1;
            cnt_raddr = cell_addr(cx, cy, cz);
            state_d   = S_EWR;
          end
        end else if (boundary) begin
          resp_st_d = ST_OK;
          state_d   = S_RESP;
        end else begin
          dx_d    = '0;
          dy_d    = '0;
          dz_d    = '0;
          total_d = '0;
          state_d = S_SRD;
        end
      end
      S_EWR: begin
        if (cnt_rdata_q >= CNTW'(CELL_CAP)) begin
          resp_st_d = ST_FULL;
        end else begin
          cnt_we    = 1'b1;
          mem_we    = 1'b1;
          resp_st_d = ST_OK;
        end
        state_d = S_RESP;
      end
      S_SRD: begin
        cnt_re  = 1'b1;
        state_d = S_SACC;
      end
      S_SACC: begin
        total_d = total_nx;
        if (nb_last) begin
          dx_d    = '0;
          dy_d    = '0;
          dz_d    = '0;
          k_d     = '0;
          trunc_d = (total_nx > TW'(MAX_OUT));
          lim_d   = (total_nx > TW'(MAX_OUT)) ? OUT_CW'(MAX_OUT) : OUT_CW'(total_nx);
          if (total_nx == '0) begin
            resp_st_d = ST_OK;
            state_d   = S_RESP;
          end else begin
            state_d = S_CRD;
          end
        end else begin
          // z fastest, then y, then x
          if (dz_q == 2'd2) begin
            dz_d = '0;
            if (dy_q == 2'd2) begin
              dy_d = '0;
              dx_d = dx_q + 2'd1;
            end else begin
              dy_d = dy_q + 2'd1;
            end
          end else begin
            dz_d = dz_q + 2'd1;
          end
          state_d = S_SRD;
        end
      end
      S_CRD: begin
        cnt_re  = 1'b1;
        cell_d  = nb_addr;
        state_d = S_CGET;
      end
      S_CGET: begin
        m_d   = '0;
        cur_d = cnt_rdata_q;
        if (cnt_rdata_q == '0) begin
          if (dz_q == 2'd2) begin
            dz_d = '0;
            if (dy_q == 2'd2) begin
              dy_d = '0;
              dx_d = dx_q + 2'd1;
            end else begin
              dy_d = dy_q + 2'd1;
            end
          end else begin
            dz_d = dz_q + 2'd1;
          end
          state_d = S_CRD;
        end else begin
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        mem_re  = 1'b1;
        state_d = S_MOUT;
      end
      S_MOUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.neighbor_id = mem_rdata_q;
          out_d.found       = 1'b1;
          out_d.last        = (k_q + OUT_CW'(1) == lim_q);
          out_d.status      = trunc_q ? ST_TRUNC : ST_OK;
          k_d               = k_q + OUT_CW'(1);
          m_d               = m_q + CNTW'(1);
          if (k_q + OUT_CW'(1) == lim_q) begin
            state_d = S_IDLE;
          end else if (m_q + CNTW'(1) == cur_q) begin
            if (dz_q == 2'd2) begin
              dz_d = '0;
              if (dy_q == 2'd2) begin
                dy_d = '0;
                dx_d = dx_q + 2'd1;
              end else begin
                dy_d = dy_q + 2'd1;
              end
            end else begin
              dz_d = dz_q + 2'd1;
            end
            state_d = S_CRD;
          end else begin
            state_d = S_MRD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.neighbor_id = '0;
          out_d.found       = 1'b0;
          out_d.last        = 1'b1;
          out_d.status      = resp_st_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      bin_cnt_q   <= 1'b0;
      clr_resp_q  <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_cnt_q   <= bin_cnt_d;
      clr_resp_q  <= clr_resp_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
    if (state_q == S_EVAL) begin
      bx_q <= cx - CW'(1);
      by_q <= cy - CW'(1);
      bz_q <= cz - CW'(1);
    end
    resp_st_q <= resp_st_d;
    cell_q    <= cell_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    dz_q      <= dz_d;
    total_q   <= total_d;
    lim_q     <= lim_d;
    k_q       <= k_d;
    trunc_q   <= trunc_d;
    m_q       <= m_d;
    cur_q     <= cur_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
